// ===== hdl/mprm_pkg.sv =====
// Package for the multi-pattern response matcher.
// Holds sizes, configuration register indexes and the action and status codes.
// No dependencies.
`default_nettype none

package mprm_pkg;

  // Number of patterns the matcher can hold and longest pattern in bytes.
  localparam int NUM_PATTERNS      = 4;
  localparam int MAX_PATTERN_BYTES = 8;

  // Pattern registers exist for four patterns, so at most four are searched.
  localparam int NUM_ACTIVE = (NUM_PATTERNS < 4) ? NUM_PATTERNS : 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 4;
  localparam int CNT_W      = 4;
  localparam int COUNT_W    = 3;
  localparam int TIMER_W    = 32;

  localparam logic [LEN_W-1:0]   MAX_LEN       = LEN_W'(MAX_PATTERN_BYTES);
  localparam logic [COUNT_W-1:0] MAX_ACTIVE    = COUNT_W'(NUM_ACTIVE);
  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = TIMER_W'(1000);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_2       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_3       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTHS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_COUNT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS      = 3'd6;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_SEARCHING = 2'd1,
    ST_FOUND     = 2'd2,
    ST_TIMEOUT   = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ===== hdl/multi_pattern_response_matcher_core.sv =====
// Multi-pattern response matcher core: byte stream search with a millisecond timeout.
// Depends on mprm_pkg for sizes, register indexes and codes.
// Each accepted input word writes its result word into the output register.
// Throughput: one word per cycle while results are taken; the per-pattern compares and
// timer update settle in one combinational pass from matcher state to output register.
// Reset: asynchronous, active low; clears match counts, timer, armed flag and the
// output valid, and returns configuration to zero with timeout_ms at 1000.
`default_nettype none

module multi_pattern_response_matcher_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration write port.
  input  wire logic                           cfg_we_i,
  input  wire logic [mprm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mprm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Input channel.
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     action_i,
  input  wire logic [7:0]                     data_byte_i,
  // Result channel.
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [1:0]                          status_o,
  output logic [1:0]                          match_index_o
);

  import mprm_pkg::*;

  // Configuration registers.
  logic [63:0]          pattern_q [4];
  logic [15:0]          lengths_q;
  logic [COUNT_W-1:0]   count_q;
  logic [TIMER_W-1:0]   timeout_q;

  // Search state.
  logic [CNT_W-1:0]     cnt_q [NUM_ACTIVE];
  logic [CNT_W-1:0]     cnt_d [NUM_ACTIVE];
  logic [TIMER_W-1:0]   elapsed_q, elapsed_d;
  logic                 searching_q, searching_d;

  // Output register.
  logic                 out_valid_q;
  logic [1:0]           status_q, status_d;
  logic [1:0]           index_q, index_d;

  logic                 in_accept;

  // Per-pattern compare results.
  logic [CNT_W-1:0]     cnt_nxt [NUM_ACTIVE];
  logic [NUM_ACTIVE-1:0] done;
  logic [COUNT_W-1:0]   active;
  logic [TIMER_W-1:0]   elapsed_inc;

  // The output register frees up in the same cycle its word is taken, so a new
  // word enters whenever the result slot is empty or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  // Number of patterns in use, limited to the patterns that exist.
  assign active = (count_q > MAX_ACTIVE) ? MAX_ACTIVE : count_q;

  // Each pattern compares the byte with its next expected byte. A miss drops the
  // count to zero without trying the byte against the first pattern byte again.
  always_comb begin
    for (int p = 0; p < NUM_ACTIVE; p++) begin
      logic [7:0]       exp_byte;
      logic [LEN_W-1:0] len_raw;
      logic [LEN_W-1:0] len;
      exp_byte = pattern_q[p][{cnt_q[p][2:0], 3'b000} +: 8];
      len_raw  = lengths_q[4*p +: 4];
      len      = (len_raw > MAX_LEN) ? MAX_LEN : len_raw;
      if (exp_byte == data_byte_i && cnt_q[p] != {CNT_W{1'b1}}) begin
        cnt_nxt[p] = cnt_q[p] + CNT_W'(1);
      end else begin
        cnt_nxt[p] = '0;
      end
      done[p] = (COUNT_W'(p) < active) && (cnt_nxt[p] >= len);
    end
  end

  // Timer saturates at its top value.
  assign elapsed_inc = (elapsed_q == {TIMER_W{1'b1}}) ? elapsed_q : elapsed_q + TIMER_W'(1);

  // Next state and result. Patterns are walked in order; the first one that
  // completes stops the walk, so patterns after it keep their counts.
  always_comb begin
    logic hit;
    hit         = 1'b0;
    cnt_d       = cnt_q;
    elapsed_d   = elapsed_q;
    searching_d = searching_q;
    status_d    = searching_q ? ST_SEARCHING : ST_IDLE;
    index_d     = '0;

    case (action_i)
      ACT_START: begin
        for (int p = 0; p < NUM_ACTIVE; p++) begin
          cnt_d[p] = '0;
        end
        elapsed_d   = '0;
        searching_d = 1'b1;
        status_d    = ST_SEARCHING;
      end
      ACT_BYTE: begin
        if (searching_q) begin
          for (int p = 0; p < NUM_ACTIVE; p++) begin
            if (!hit && COUNT_W'(p) < active) begin
              cnt_d[p] = cnt_nxt[p];
              if (done[p]) begin
                hit         = 1'b1;
                searching_d = 1'b0;
                status_d    = ST_FOUND;
                index_d     = 2'(p);
              end
            end
          end
        end
      end
      ACT_TICK: begin
        if (searching_q) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= timeout_q) begin
            searching_d = 1'b0;
            status_d    = ST_TIMEOUT;
          end
        end
      end
      default: begin
        // Unused action code: nothing changes, status reflects the armed flag.
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        pattern_q[i] <= '0;
      end
      lengths_q <= '0;
      count_q   <= '0;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PATTERN_0:       pattern_q[0] <= cfg_wdata_i;
        REG_PATTERN_1:       pattern_q[1] <= cfg_wdata_i;
        REG_PATTERN_2:       pattern_q[2] <= cfg_wdata_i;
        REG_PATTERN_3:       pattern_q[3] <= cfg_wdata_i;
        REG_PATTERN_LENGTHS: lengths_q    <= cfg_wdata_i[15:0];
        REG_PATTERN_COUNT:   count_q      <= cfg_wdata_i[COUNT_W-1:0];
        REG_TIMEOUT_MS:      timeout_q    <= cfg_wdata_i[TIMER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Search state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_ACTIVE; p++) begin
        cnt_q[p] <= '0;
      end
      elapsed_q   <= '0;
      searching_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        cnt_q       <= cnt_d;
        elapsed_q   <= elapsed_d;
        searching_q <= searching_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      status_q <= status_d;
      index_q  <= index_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign match_index_o = index_q;

  // A start word always answers searching.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && action_i == ACT_START |=> out_valid_o && status_o == ST_SEARCHING)
    else $error("start word did not report searching");

  // The index is only meaningful for a found result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_FOUND |-> match_index_o == 2'd0)
    else $error("nonzero match index without found status");

  // A found or timeout word waiting in the output register means the search is disarmed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FOUND || status_o == ST_TIMEOUT) |-> !searching_q)
    else $error("search still armed after found or timeout");

  // A byte while disarmed is ignored and reports idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && action_i == ACT_BYTE && !searching_q |=> status_o == ST_IDLE && !searching_q)
    else $error("byte while disarmed was not ignored");

endmodule

`default_nettype wire
